// ----- rtl/core/gbn_sw_pkg.sv -----
// package with opcodes, result kinds and field widths of the go-back-n sender window
`default_nettype none

package gbn_sw_pkg;

  localparam int OPCODE_W = 2;
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 3;
  localparam int OUTST_W  = 9;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [OUTST_W-1:0]  outst_t;

  localparam opcode_t OP_SEND    = 2'd0;
  localparam opcode_t OP_ACK     = 2'd1;
  localparam opcode_t OP_TIMEOUT = 2'd2;

  localparam kind_t KIND_SENT        = 3'd0;
  localparam kind_t KIND_RESENT      = 3'd1;
  localparam kind_t KIND_ACK_TAKEN   = 3'd2;
  localparam kind_t KIND_ACK_IGNORED = 3'd3;
  localparam kind_t KIND_REFUSED     = 3'd4;
  localparam kind_t KIND_EMPTY_TMO   = 3'd5;

endpackage

`default_nettype wire

// ----- rtl/core/go_back_n_sender_window.sv -----
// go-back-n sender window: payload store, cumulative ack and timeout replay
//
//  channel  ports                               handshake
//  -------  ----------------------------------  ----------------------------
//  input    in_opcode in_data_byte in_ack_seqn  start high and busy low
//  result   out_kind out_seqn out_payload       out_valid, one cycle, taken
//           out_last out_outstanding            at the edge that ends it
//           out_window_empty
//
//  a send or an ack gives its result in the cycle after acceptance and busy
//  stays low, so one such item can be taken every cycle
//  a timeout with k entries outstanding reads the window memory one entry a
//  cycle: busy is high while the k entries are read, and the results come
//  out one per cycle, each registered after its read at the memory read port
//  reset is synchronous; the window memory is not cleared
//  the receiver cannot stall; results are never held back
`default_nettype none

module go_back_n_sender_window #(
  parameter int WINDOW_SIZE = 8
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  gbn_sw_pkg::opcode_t    in_opcode,
  input  gbn_sw_pkg::byte_t      in_data_byte,
  input  gbn_sw_pkg::byte_t      in_ack_seqn,
  output logic                   out_valid,
  output gbn_sw_pkg::kind_t      out_kind,
  output gbn_sw_pkg::byte_t      out_seqn,
  output gbn_sw_pkg::byte_t      out_payload,
  output logic                   out_last,
  output gbn_sw_pkg::outst_t     out_outstanding,
  output logic                   out_window_empty
);

  import gbn_sw_pkg::*;

  localparam int SEQ_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CNT_W = $clog2(WINDOW_SIZE + 1);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REPLAY = 1'b1;

  localparam logic [SEQ_W-1:0] SEQ_MAX = SEQ_W'(WINDOW_SIZE - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_SIZE);

  logic [BYTE_W-1:0] window_store [WINDOW_SIZE];
  logic [BYTE_W-1:0] rd_data_r;

  logic              state_r, state_nxt;
  logic [SEQ_W-1:0]  next_seqn_r, next_seqn_nxt;
  logic [SEQ_W-1:0]  last_acked_r, last_acked_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SEQ_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;

  logic              valid_r, valid_nxt;
  kind_t             kind_r, kind_nxt;
  logic [SEQ_W-1:0]  seqn_r, seqn_nxt;
  byte_t             pay_r, pay_nxt;
  logic              last_r, last_nxt;
  logic              from_mem_r, from_mem_nxt;
  logic [CNT_W-1:0]  cnt_out_r;

  logic              accept;
  logic              mem_we;
  logic              mem_re;
  logic [SEQ_W-1:0]  ack_lo;
  logic [SEQ_W:0]    retire_w;
  logic              ack_big;

  assign busy   = (state_r == ST_REPLAY);
  assign accept = start && !busy;
  assign mem_re = (state_r == ST_REPLAY);

  assign ack_lo  = in_ack_seqn[SEQ_W-1:0];
  assign ack_big = ({1'b0, in_ack_seqn} >= 9'(WINDOW_SIZE));

  always_comb begin
    if (ack_lo >= last_acked_r) begin
      retire_w = {1'b0, ack_lo} - {1'b0, last_acked_r};
    end else begin
      retire_w = {1'b0, ack_lo} + (SEQ_W+1)'(WINDOW_SIZE) - {1'b0, last_acked_r};
    end
  end

  always_comb begin
    state_nxt      = state_r;
    next_seqn_nxt  = next_seqn_r;
    last_acked_nxt = last_acked_r;
    count_nxt      = count_r;
    rd_ptr_nxt     = rd_ptr_r;
    rem_nxt        = rem_r;
    valid_nxt      = 1'b0;
    kind_nxt       = kind_r;
    seqn_nxt       = '0;
    pay_nxt        = '0;
    last_nxt       = 1'b1;
    from_mem_nxt   = 1'b0;
    mem_we         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_SEND: begin
              valid_nxt = 1'b1;
              if (count_r == CNT_FULL) begin
                kind_nxt = KIND_REFUSED;
              end else begin
                mem_we        = 1'b1;
                kind_nxt      = KIND_SENT;
                seqn_nxt      = next_seqn_r;
                pay_nxt       = in_data_byte;
                next_seqn_nxt = (next_seqn_r == SEQ_MAX) ? '0 : next_seqn_r + 1'b1;
                count_nxt     = count_r + 1'b1;
              end
            end
            OP_ACK: begin
              valid_nxt = 1'b1;
              if (ack_big || (10'(retire_w) > 10'(count_r))) begin
                kind_nxt = KIND_ACK_IGNORED;
              end else begin
                kind_nxt       = KIND_ACK_TAKEN;
                count_nxt      = count_r - CNT_W'(retire_w);
                last_acked_nxt = ack_lo;
              end
            end
            OP_TIMEOUT: begin
              if (count_r == '0) begin
                valid_nxt = 1'b1;
                kind_nxt  = KIND_EMPTY_TMO;
              end else begin
                state_nxt  = ST_REPLAY;
                rd_ptr_nxt = (last_acked_r == SEQ_MAX) ? '0 : last_acked_r + 1'b1;
                rem_nxt    = count_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_REPLAY: begin
        valid_nxt    = 1'b1;
        kind_nxt     = KIND_RESENT;
        seqn_nxt     = rd_ptr_r;
        from_mem_nxt = 1'b1;
        last_nxt     = (rem_r == CNT_W'(1));
        rd_ptr_nxt   = (rd_ptr_r == SEQ_MAX) ? '0 : rd_ptr_r + 1'b1;
        rem_nxt      = rem_r - 1'b1;
        if (rem_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // window memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      window_store[next_seqn_r] <= in_data_byte;
    end
    if (mem_re) begin
      rd_data_r <= window_store[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      next_seqn_r  <= '0;
      last_acked_r <= SEQ_MAX;
      count_r      <= '0;
      valid_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_seqn_r  <= next_seqn_nxt;
      last_acked_r <= last_acked_nxt;
      count_r      <= count_nxt;
      valid_r      <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    rem_r      <= rem_nxt;
    kind_r     <= kind_nxt;
    seqn_r     <= seqn_nxt;
    pay_r      <= pay_nxt;
    last_r     <= last_nxt;
    from_mem_r <= from_mem_nxt;
    cnt_out_r  <= count_nxt;
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_seqn         = BYTE_W'(seqn_r);
  assign out_payload      = from_mem_r ? rd_data_r : pay_r;
  assign out_last         = last_r;
  assign out_outstanding  = OUTST_W'(cnt_out_r);
  assign out_window_empty = (cnt_out_r == '0);

`ifndef NO_ASSERTIONS
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == OP_SEND || in_opcode == OP_ACK))
      |=> (out_valid && out_last))
    else $error("send or ack did not give one final result");

  a_resent_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_RESENT) |-> (out_outstanding != '0))
    else $error("resent item with empty window");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_outstanding <= OUTST_W'(WINDOW_SIZE)))
    else $error("outstanding count beyond window size");

  a_replay_stream: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && out_kind == KIND_RESENT))
    else $error("replay cycle without resent item");
`endif

endmodule

`default_nettype wire
